// File: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared definitions for the environmental sensor compensation block
// Field widths, stream widths, configuration indices and sign and zero extension helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int RAW_P_W   = 20;
    localparam int RAW_T_W   = 20;
    localparam int RAW_H_W   = 16;
    localparam int TEMP_W    = 27;
    localparam int PRESS_W   = 32;
    localparam int HUM_W     = 17;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 80;
    localparam int COEF_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [HUM_W-1:0] HUM_FULL_SCALE = 17'd102400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TEMP    = 2'd0,
        CFG_COEF_PRESS_A = 2'd1,
        CFG_COEF_PRESS_B = 2'd2,
        CFG_COEF_HUM     = 2'd3
    } cfg_idx_t;

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] sx12(input logic [11:0] v);
        return {{52{v[11]}}, v};
    endfunction

    function automatic logic signed [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic signed [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [63:0] zx16(input logic [15:0] v);
        return {48'd0, v};
    endfunction

endpackage

`default_nettype wire

// File: src/esc_mul.sv
// ----------------------------------------------------------------------------
// esc_mul: iterative 64 x 64 multiplier, low 64 bits of the product
// Three 32 x 32 partial products through one multiplier, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output logic             done,
    output logic [63:0]      product
);
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx;
    logic [31:0] my;

    // Partial products: low x low, low x high, high x low.
    always_comb
    begin
        mx = (cnt_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        my = (cnt_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            prod_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            a_reg    <= op_a;
            b_reg    <= op_b;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg != 2'd3)
            begin
                prod_reg <= {32'd0, mx} * {32'd0, my};
            end
            case (cnt_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            endcase
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: src/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div: signed 64-bit divider, quotient truncated toward zero
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quo
);
    logic [64:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] d_reg;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        fits;

    always_comb
    begin
        rem_sh  = {rem_reg[63:0], q_reg[63]};
        rem_sub = rem_sh - {1'b0, d_reg};
        fits    = (rem_sh >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            q_reg    <= '0;
            d_reg    <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            q_reg    <= num[63] ? (64'd0 - num) : num;
            d_reg    <= den[63] ? (64'd0 - den) : den;
            neg_reg  <= num[63] ^ den[63];
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub : rem_sh;
            q_reg   <= {q_reg[62:0], fits};
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // The most negative value over minus one wraps back onto itself here.
            quo_reg  <= neg_reg ? (64'd0 - q_reg) : q_reg;
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: src/env_sensor_compensation.sv
// Each item makes 21 passes through the shared multiplier and one through the divider
// when the pressure divisor is nonzero; a zero divisor ends the item after the
// OP_P_A1 pass, before the divider and the humidity steps.
// Throughput: one item at a time; the next item is taken after the result is taken.
// Reset (rst_n, asynchronous, active low) clears coefficients and held pressure and
// humidity to zero.
// ----------------------------------------------------------------------------
// env_sensor_compensation: integer temperature, pressure, humidity compensation
// A step sequencer drives one shared multiplier and a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // raw_pressure [19:0], raw_temperature [39:20], raw_humidity [55:40]
    input  wire logic [esc_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // temperature_centi [26:0], pressure_q24_8 [58:27], humidity_q7_10 [75:59]
    output logic [esc_pkg::M_DATA_W-1:0]           m_tdata,
    // pressure_error [0]
    output logic [0:0]                             m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [esc_pkg::COEF_W-1:0]        cfg_data
);
    import esc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_MWAIT,
        S_DWAIT,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_T_LIN, OP_T_SQ, OP_T_QUAD, OP_P_SQ, OP_P_B6, OP_P_B5, OP_P_A3, OP_P_A2,
        OP_P_A1, OP_P_NUM, OP_P_C9A, OP_P_C9B, OP_P_C8, OP_H_X, OP_H_U, OP_H_W,
        OP_H_Y0, OP_H_Y, OP_H_V, OP_H_ZZ, OP_H_FIN
    } step_t;

    state_t               state_reg, state_next;
    step_t                step_reg, step_next;
    logic [COEF_W-1:0]    coef_temp_reg, coef_pa_reg, coef_pb_reg, coef_hum_reg;
    logic [RAW_P_W-1:0]   rp_reg, rp_next;
    logic [RAW_T_W-1:0]   rt_reg, rt_next;
    logic [RAW_H_W-1:0]   rh_reg, rh_next;
    logic signed [63:0]   a_reg, a_next, b_reg, b_next, tf_reg, tf_next;
    logic signed [63:0]   sq_reg, sq_next, p_reg, p_next;
    logic signed [31:0]   x_reg, x_next, y_reg, y_next;
    logic [TEMP_W-1:0]    temp_reg, temp_next;
    logic [PRESS_W-1:0]   press_reg, press_next;
    logic [HUM_W-1:0]     hum_reg, hum_next;
    logic                 err_reg, err_next;

    logic                 mul_start, mul_done, div_start, div_done;
    logic [63:0]          mul_a, mul_b, mul_p, div_q;
    logic signed [63:0]   m_s, pa, p13, v64, t_new, t5, a_new, pn;
    logic signed [31:0]   m32, v32, hx, hv;
    logic signed [63:0]   c_t1, c_t2, c_t3, c_p1, c_p2, c_p3, c_p4, c_p5;
    logic signed [63:0]   c_p6, c_p7, c_p8, c_p9, c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

    always_comb
    begin
        c_t1 = zx16(coef_temp_reg[15:0]);
        c_t2 = sx16(coef_temp_reg[31:16]);
        c_t3 = sx16(coef_temp_reg[47:32]);
        c_p1 = zx16(coef_temp_reg[63:48]);
        c_p2 = sx16(coef_pa_reg[15:0]);
        c_p3 = sx16(coef_pa_reg[31:16]);
        c_p4 = sx16(coef_pa_reg[47:32]);
        c_p5 = sx16(coef_pa_reg[63:48]);
        c_p6 = sx16(coef_pb_reg[15:0]);
        c_p7 = sx16(coef_pb_reg[31:16]);
        c_p8 = sx16(coef_pb_reg[47:32]);
        c_p9 = sx16(coef_pb_reg[63:48]);
        c_h1 = {56'd0, coef_hum_reg[7:0]};
        c_h2 = sx16(coef_hum_reg[23:8]);
        c_h3 = {56'd0, coef_hum_reg[31:24]};
        c_h4 = sx12(coef_hum_reg[43:32]);
        c_h5 = sx12(coef_hum_reg[55:44]);
        c_h6 = sx8(coef_hum_reg[63:56]);
    end

    esc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_p),
        .den   (a_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    // Shared values seen by several steps.
    always_comb
    begin
        m_s = mul_p;
        m32 = mul_p[31:0];
        pa  = tf_reg - 64'sd128000;
        p13 = p_reg >>> 13;
        v32 = tf_reg[31:0] - 32'sd76800;
        v64 = sx32(v32);
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            OP_T_LIN:
            begin
                mul_a = {47'd0, rt_reg[19:3]} - {c_t1[62:0], 1'b0};
                mul_b = c_t2;
            end
            OP_T_SQ:
            begin
                mul_a = {48'd0, rt_reg[19:4]} - c_t1;
                mul_b = {48'd0, rt_reg[19:4]} - c_t1;
            end
            OP_T_QUAD: begin mul_a = b_reg;   mul_b = c_t3; end
            OP_P_SQ:   begin mul_a = pa;      mul_b = pa;   end
            OP_P_B6:   begin mul_a = sq_reg;  mul_b = c_p6; end
            OP_P_B5:   begin mul_a = pa;      mul_b = c_p5; end
            OP_P_A3:   begin mul_a = sq_reg;  mul_b = c_p3; end
            OP_P_A2:   begin mul_a = pa;      mul_b = c_p2; end
            OP_P_A1:   begin mul_a = a_reg + (64'sd1 <<< 47); mul_b = c_p1; end
            OP_P_NUM:
            begin
                mul_a = ((64'sd1048576 - {44'd0, rp_reg}) <<< 31) - b_reg;
                mul_b = 64'sd3125;
            end
            OP_P_C9A:  begin mul_a = c_p9;    mul_b = p13;  end
            OP_P_C9B:  begin mul_a = a_reg;   mul_b = p13;  end
            OP_P_C8:   begin mul_a = c_p8;    mul_b = p_reg; end
            OP_H_X:    begin mul_a = c_h5;    mul_b = v64;  end
            OP_H_U:    begin mul_a = v64;     mul_b = c_h6; end
            OP_H_W:    begin mul_a = v64;     mul_b = c_h3; end
            OP_H_Y0:   begin mul_a = sx32(y_reg); mul_b = a_reg; end
            OP_H_Y:    begin mul_a = sx32(y_reg); mul_b = c_h2;  end
            OP_H_V:    begin mul_a = sx32(x_reg); mul_b = sx32(y_reg); end
            OP_H_ZZ:
            begin
                mul_a = sx32(x_reg >>> 15);
                mul_b = sx32(x_reg >>> 15);
            end
            OP_H_FIN:  begin mul_a = sx32(y_reg); mul_b = c_h1; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_start = (state_reg == S_ISSUE);
    assign div_start = (state_reg == S_MWAIT) && mul_done && (step_reg == OP_P_NUM);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rp_next    = rp_reg;
        rt_next    = rt_reg;
        rh_next    = rh_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        tf_next    = tf_reg;
        sq_next    = sq_reg;
        p_next     = p_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        temp_next  = temp_reg;
        press_next = press_reg;
        hum_next   = hum_reg;
        err_next   = err_reg;
        t_new      = a_reg + (m_s >>> 14);
        t5         = ((t_new <<< 2) + t_new + 64'sd128) >>> 8;
        a_new      = m_s >>> 33;
        pn         = ((p_reg + a_reg + (m_s >>> 19)) >>> 8) + (c_p7 <<< 4);
        hx         = $signed(({16'd0, rh_reg} <<< 14) - (c_h4[31:0] <<< 20) - m32
                      + 32'sd16384) >>> 15;
        hv         = x_reg - ((m32) >>> 4);

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    rp_next    = s_tdata[19:0];
                    rt_next    = s_tdata[39:20];
                    rh_next    = s_tdata[55:40];
                    step_next  = OP_T_LIN;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    step_next  = step_t'(step_reg + 5'd1);
                    state_next = S_ISSUE;
                    case (step_reg)
                        OP_T_LIN:  a_next = m_s >>> 11;
                        OP_T_SQ:   b_next = m_s >>> 12;
                        OP_T_QUAD:
                        begin
                            tf_next   = t_new;
                            temp_next = t5[TEMP_W-1:0];
                        end
                        OP_P_SQ:   sq_next = m_s;
                        OP_P_B6:   b_next  = m_s;
                        OP_P_B5:   b_next  = b_reg + (m_s <<< 17) + (c_p4 <<< 35);
                        OP_P_A3:   a_next  = m_s >>> 8;
                        OP_P_A2:   a_next  = a_reg + (m_s <<< 12);
                        OP_P_A1:
                        begin
                            a_next = a_new;
                            // A zero divisor ends the item with the held values.
                            if (a_new == 64'sd0)
                            begin
                                err_next   = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                err_next = 1'b0;
                            end
                        end
                        OP_P_NUM:  state_next = S_DWAIT;
                        OP_P_C9A:  a_next = m_s;
                        OP_P_C9B:  a_next = m_s >>> 25;
                        OP_P_C8:
                        begin
                            p_next     = pn;
                            press_next = pn[PRESS_W-1:0];
                        end
                        OP_H_X:    x_next = hx;
                        OP_H_U:    y_next = m32 >>> 10;
                        OP_H_W:    a_next = sx32((m32 >>> 11) + 32'sd32768);
                        OP_H_Y0:   y_next = (m32 >>> 10) + 32'sd2097152;
                        OP_H_Y:    y_next = (m32 + 32'sd8192) >>> 14;
                        OP_H_V:    x_next = m32;
                        OP_H_ZZ:   y_next = m32 >>> 7;
                        OP_H_FIN:
                        begin
                            if (hv < 32'sd0)
                            begin
                                hum_next = '0;
                            end
                            else if (hv > 32'sd419430400)
                            begin
                                hum_next = HUM_FULL_SCALE;
                            end
                            else
                            begin
                                hum_next = hv[28:12];
                            end
                            state_next = S_OUT;
                        end
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    p_next     = div_q;
                    step_next  = OP_P_C9A;
                    state_next = S_ISSUE;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= OP_T_LIN;
            coef_temp_reg <= '0;
            coef_pa_reg   <= '0;
            coef_pb_reg   <= '0;
            coef_hum_reg  <= '0;
            rp_reg        <= '0;
            rt_reg        <= '0;
            rh_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            tf_reg        <= '0;
            sq_reg        <= '0;
            p_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            temp_reg      <= '0;
            press_reg     <= '0;
            hum_reg       <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rp_reg    <= rp_next;
            rt_reg    <= rt_next;
            rh_reg    <= rh_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            tf_reg    <= tf_next;
            sq_reg    <= sq_next;
            p_reg     <= p_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            temp_reg  <= temp_next;
            press_reg <= press_next;
            hum_reg   <= hum_next;
            err_reg   <= err_next;
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COEF_TEMP:    coef_temp_reg <= cfg_data;
                    CFG_COEF_PRESS_A: coef_pa_reg   <= cfg_data;
                    CFG_COEF_PRESS_B: coef_pb_reg   <= cfg_data;
                    CFG_COEF_HUM:     coef_hum_reg  <= cfg_data;
                    default:          coef_temp_reg <= coef_temp_reg;
                endcase
            end
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {4'd0, hum_reg, press_reg, temp_reg};
    assign m_tuser   = err_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: src/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_props: port-level checks for the compensation block
// Watches the stream ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_props (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [esc_pkg::M_DATA_W-1:0] m_tdata
);
    import esc_pkg::*;

    // A result waiting to be taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // One item in flight: never ready for input while a result is offered.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("block not busy after taking an item");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[75:59] <= HUM_FULL_SCALE)
        else $error("humidity above full scale");

endmodule

bind env_sensor_compensation esc_props u_esc_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
